// ===== rtl/core/bdq_pkg.sv =====
// Shared request, status and cell control types for the bounded deque.
package bdq_pkg;

   localparam int unsigned REQ_TYPE_W = 3;
   localparam int unsigned STATUS_W   = 2;
   localparam int unsigned VALUE_W    = 32;

   typedef enum logic [REQ_TYPE_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_SEARCH     = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_MISS  = 2'd3
   } status_type;

   typedef struct packed {
      logic push_front;
      logic push_back;
      logic pop_front;
      logic search;
   } ctrl_type;

endpackage

// ===== rtl/core/bdq_req_if.sv =====
// Request channel: operation code and value with valid/ready.
interface bdq_req_if;
   logic                               valid;
   logic                               ready;
   logic [bdq_pkg::REQ_TYPE_W-1:0]     req_type;
   logic signed [bdq_pkg::VALUE_W-1:0] value;

   modport source (output valid, output req_type, output value, input ready);
   modport sink   (input valid, input req_type, input value, output ready);
endinterface

// ===== rtl/core/bdq_rsp_if.sv =====
// Response channel: status and resulting entry count with valid/ready.
interface bdq_rsp_if #(
   parameter int CNT_W = 5
);
   logic                           valid;
   logic                           ready;
   logic [bdq_pkg::STATUS_W-1:0]   status;
   logic [CNT_W-1:0]               count;

   modport source (output valid, output status, output count, input ready);
   modport sink   (input valid, input status, input count, output ready);
endinterface

// ===== rtl/core/bdq_cell.sv =====
// One deque slot: holds an entry, shifts with its neighbors and compares on search.
module bdq_cell #(
   parameter int DATA_WIDTH = 32,
   parameter int CNT_W      = 5,
   parameter int INDEX      = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bdq_pkg::ctrl_type     ctrl,
   input  logic [CNT_W-1:0]      count,
   input  logic [DATA_WIDTH-1:0] value,
   input  logic [DATA_WIDTH-1:0] left_data,
   input  logic [DATA_WIDTH-1:0] right_data,
   output logic [DATA_WIDTH-1:0] data,
   output logic                  match
);
   import bdq_pkg::*;

   localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

   logic [DATA_WIDTH-1:0] data_ff, data_in;
   logic                  match_ff, match_in;

   always_comb begin
      data_in  = data_ff;
      match_in = match_ff;
      if (ctrl.push_front) begin
         data_in = left_data;
      end else if (ctrl.push_back && (count == IDX)) begin
         data_in = value;
      end else if (ctrl.pop_front) begin
         data_in = right_data;
      end
      if (ctrl.search) begin
         match_in = (IDX < count) && (data_ff == value);
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   assign data  = data_ff;
   assign match = match_ff;
endmodule

// ===== rtl/core/bounded_deque_with_search_core.sv =====
// Bounded double-ended queue with membership search, built as a chain of cells.
//
//   channel | dir | transfer when        | payload
//   --------+-----+----------------------+---------------------------
//   req_bus | in  | valid && ready       | req_type, value
//   rsp_bus | out | valid && ready       | status, count
//
// The cells update and register their compare results at acceptance;
// once the response register is free, the match bits are OR-reduced and
// the response is registered. One request is in flight.
// Reset clears the count and the handshake state; entry contents are not cleared.
// A stalled response holds req_bus.ready low until the response register frees.
module bounded_deque_with_search_core #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input logic       clock,
   input logic       reset,
   bdq_req_if.sink   req_bus,
   bdq_rsp_if.source rsp_bus
);
   import bdq_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             busy_ff, busy_in;
   logic             pend_search_ff, pend_search_in;
   status_type       pend_status_ff, pend_status_in;
   logic [CNT_W-1:0] pend_count_ff, pend_count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic                  accept;
   logic                  full;
   logic                  empty;
   logic                  release_rsp;
   op_type                op;
   ctrl_type              ctrl;
   status_type            req_status;
   logic [DATA_WIDTH-1:0] value_w;
   logic [DATA_WIDTH-1:0] cell_data [DEPTH];
   logic [DEPTH-1:0]      match_vec;

   generate
      if (DATA_WIDTH <= VALUE_W) begin : g_trunc
         assign value_w = req_bus.value[DATA_WIDTH-1:0];
      end else begin : g_sext
         assign value_w = {{(DATA_WIDTH - VALUE_W){req_bus.value[VALUE_W-1]}}, req_bus.value};
      end
   endgenerate

   assign req_bus.ready = !busy_ff;
   assign accept        = req_bus.valid && !busy_ff;
   assign full          = (count_ff == FULL_CNT);
   assign empty         = (count_ff == '0);
   assign op            = op_type'(req_bus.req_type);
   assign release_rsp   = busy_ff && (!rsp_valid_ff || rsp_bus.ready);

   always_comb begin
      ctrl       = '0;
      req_status = ST_OK;
      count_in   = count_ff;
      case (op)
         OP_PUSH_FRONT: begin
            if (full) begin
               req_status = ST_FULL;
            end else begin
               ctrl.push_front = accept;
               count_in        = count_ff + ONE_CNT;
            end
         end
         OP_PUSH_BACK: begin
            if (full) begin
               req_status = ST_FULL;
            end else begin
               ctrl.push_back = accept;
               count_in       = count_ff + ONE_CNT;
            end
         end
         OP_POP_FRONT: begin
            if (empty) begin
               req_status = ST_EMPTY;
            end else begin
               ctrl.pop_front = accept;
               count_in       = count_ff - ONE_CNT;
            end
         end
         OP_POP_BACK: begin
            if (empty) begin
               req_status = ST_EMPTY;
            end else begin
               count_in = count_ff - ONE_CNT;
            end
         end
         OP_SEARCH: begin
            if (empty) begin
               req_status = ST_EMPTY;
            end else begin
               ctrl.search = accept;
            end
         end
         default: begin
            req_status = ST_OK;
         end
      endcase
      if (!accept) begin
         count_in = count_ff;
      end
   end

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         logic [DATA_WIDTH-1:0] left_d;
         logic [DATA_WIDTH-1:0] right_d;
         if (i == 0) begin : g_head
            assign left_d = value_w;
         end else begin : g_mid
            assign left_d = cell_data[i-1];
         end
         if (i == DEPTH - 1) begin : g_tail
            assign right_d = cell_data[i];
         end else begin : g_inner
            assign right_d = cell_data[i+1];
         end
         bdq_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CNT_W      (CNT_W),
            .INDEX      (i)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .count      (count_ff),
            .value      (value_w),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i]),
            .match      (match_vec[i])
         );
      end
   endgenerate

   always_comb begin
      busy_in        = busy_ff;
      pend_search_in = pend_search_ff;
      pend_status_in = pend_status_ff;
      pend_count_in  = pend_count_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_count_in   = rsp_count_ff;
      if (accept) begin
         busy_in        = 1'b1;
         pend_search_in = ctrl.search;
         pend_status_in = req_status;
         pend_count_in  = count_in;
      end
      if (release_rsp) begin
         busy_in       = 1'b0;
         rsp_valid_in  = 1'b1;
         rsp_count_in  = pend_count_ff;
         rsp_status_in = pend_status_ff;
         if (pend_search_ff) begin
            rsp_status_in = (|match_vec) ? ST_OK : ST_MISS;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_search_ff <= pend_search_in;
      pend_status_ff <= pend_status_in;
      pend_count_ff  <= pend_count_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.status = rsp_status_ff;
   assign rsp_bus.count  = rsp_count_ff;
endmodule

// ===== rtl/core/bdq_checker.sv =====
// Port-level checks for the bounded deque core and their bind.
module bdq_checker #(
   parameter int DEPTH = 16,
   parameter int CNT_W = 5
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [bdq_pkg::STATUS_W-1:0] rsp_status,
   input logic [CNT_W-1:0]             rsp_count
);
   import bdq_pkg::*;

   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while another is in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status) && $stable(rsp_count)))
      else $error("stalled response changed");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_FULL)) |-> (rsp_count == FULL_CNT))
      else $error("full status with count below depth");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ((rsp_status == ST_EMPTY) || (rsp_status == ST_MISS)))
         |-> ((rsp_status == ST_EMPTY) ? (rsp_count == '0) : (rsp_count != '0)))
      else $error("count disagrees with empty or miss status");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_count <= FULL_CNT))
      else $error("count beyond depth");
endmodule

bind bounded_deque_with_search_core bdq_checker #(
   .DEPTH (DEPTH),
   .CNT_W (CNT_W)
) u_bdq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_status (rsp_bus.status),
   .rsp_count  (rsp_bus.count)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the bounded deque: directed corners, then random traffic.
module tb_top;
   import bdq_pkg::*;

   localparam int DEPTH          = 16;
   localparam int DATA_WIDTH     = 32;
   localparam int CNT_W          = 5;
   localparam int STALL_LIMIT    = 4000;
   localparam int MAX_REPORTED   = 10;
   localparam int DRAIN_CYCLES   = 8;
   localparam logic [REQ_TYPE_W-1:0] REQ_CODE_MAX = 3'd7;
   localparam logic [REQ_TYPE_W-1:0] REQ_CODE_UNUSED = 3'(int'(OP_SEARCH) + 1);
   localparam logic [VALUE_W-1:0] VAL_MIN = 32'h8000_0000;
   localparam logic [VALUE_W-1:0] VAL_MAX = 32'h7fff_ffff;
   localparam logic [VALUE_W-1:0] VAL_ONES = 32'hffff_ffff;

   typedef struct {
      status_type       status;
      logic [CNT_W-1:0] count;
   } deque_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bdq_req_if req_bus();
   bdq_rsp_if #(.CNT_W(CNT_W)) rsp_bus();

   bounded_deque_with_search_core #(
      .DEPTH(DEPTH),
      .DATA_WIDTH(DATA_WIDTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   logic [DATA_WIDTH-1:0] deque_model[$];
   deque_rsp_type         pending_rsp[$];
   deque_rsp_type         head_rsp;
   int                    mismatch_count = 0;
   int                    idle_cycles = 0;
   int                    send_idle_pct = 0;
   int                    recv_stall_pct = 0;

   always #1 clock = ~clock;

   function automatic deque_rsp_type predict_response(input logic [REQ_TYPE_W-1:0] code,
                                                      input logic [VALUE_W-1:0] data);
      deque_rsp_type r;
      logic          hit;
      r.status = ST_OK;
      hit = 1'b0;
      case (code)
         OP_PUSH_FRONT: begin
            if (deque_model.size() >= DEPTH) r.status = ST_FULL;
            else deque_model.push_front(data[DATA_WIDTH-1:0]);
         end
         OP_PUSH_BACK: begin
            if (deque_model.size() >= DEPTH) r.status = ST_FULL;
            else deque_model.push_back(data[DATA_WIDTH-1:0]);
         end
         OP_POP_FRONT: begin
            if (deque_model.size() == 0) r.status = ST_EMPTY;
            else void'(deque_model.pop_front());
         end
         OP_POP_BACK: begin
            if (deque_model.size() == 0) r.status = ST_EMPTY;
            else void'(deque_model.pop_back());
         end
         OP_SEARCH: begin
            if (deque_model.size() == 0) begin
               r.status = ST_EMPTY;
            end else begin
               foreach (deque_model[k]) if (deque_model[k] == data[DATA_WIDTH-1:0]) hit = 1'b1;
               r.status = hit ? ST_OK : ST_MISS;
            end
         end
         default: ;
      endcase
      r.count = CNT_W'(deque_model.size());
      return r;
   endfunction

   task automatic send_request(input logic [REQ_TYPE_W-1:0] code,
                               input logic [VALUE_W-1:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid    = 1'b1;
      req_bus.req_type = code;
      req_bus.value    = data;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      pending_rsp.push_back(predict_response(code, data));
      @(negedge clock);
   endtask

   function automatic logic [VALUE_W-1:0] pick_value();
      int r;
      r = $urandom_range(99);
      if (r < 50) return VALUE_W'($urandom_range(15)) - VALUE_W'(8);
      if (r < 60) begin
         case ($urandom_range(3))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return VAL_ONES;
            default: return '0;
         endcase
      end
      return $urandom;
   endfunction

   function automatic logic [VALUE_W-1:0] pick_search_value();
      logic [VALUE_W-1:0] v;
      int                 r;
      r = $urandom_range(99);
      if (deque_model.size() == 0 || r >= 70) return pick_value();
      v = VALUE_W'(deque_model[$urandom_range(deque_model.size() - 1)]);
      if (r >= 50) v[$urandom_range(VALUE_W - 1)] ^= 1'b1;
      return v;
   endfunction

   task automatic test_empty_requests();
      send_request(OP_POP_FRONT, VAL_ONES);
      send_request(OP_POP_BACK, '0);
      send_request(OP_SEARCH, '0);
      send_request(REQ_CODE_MAX, VAL_ONES);
   endtask

   task automatic test_fill_to_full();
      send_request(OP_PUSH_BACK, VAL_MIN);
      send_request(OP_PUSH_FRONT, VAL_MAX);
      send_request(OP_PUSH_BACK, '0);
      send_request(OP_PUSH_FRONT, VAL_ONES);
      for (int k = 0; k < DEPTH - 4; k++) begin
         if (k % 2 == 0) send_request(OP_PUSH_BACK, 32'h5555_5555 ^ VALUE_W'(k));
         else send_request(OP_PUSH_FRONT, 32'haaaa_aaaa ^ VALUE_W'(k));
      end
      send_request(OP_PUSH_FRONT, 32'h1234_5678);
      send_request(OP_PUSH_BACK, 32'h8765_4321);
      send_request(REQ_CODE_UNUSED, VAL_MIN);
   endtask

   task automatic test_search_and_pops();
      send_request(OP_SEARCH, VAL_MIN);
      send_request(OP_SEARCH, 32'h7fff_fffe);
      send_request(OP_SEARCH, VAL_ONES);
      send_request(OP_POP_FRONT, '0);
      send_request(OP_POP_BACK, VAL_ONES);
      send_request(OP_SEARCH, VAL_ONES);
   endtask

   task automatic test_random_traffic(input int n_items, input int idle_pct,
                                      input int stall_pct);
      logic filling;
      int   r;
      filling        = 1'b1;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      for (int i = 0; i < n_items; i++) begin
         if (deque_model.size() == DEPTH && $urandom_range(3) == 0) filling = 1'b0;
         if (deque_model.size() == 0 && $urandom_range(3) == 0) filling = 1'b1;
         r = $urandom_range(99);
         if (r < 5)
            send_request(3'($urandom_range(REQ_CODE_MAX, REQ_CODE_UNUSED)), $urandom);
         else if (r < 22)
            send_request(OP_SEARCH, pick_search_value());
         else if (filling ? (r < 80) : (r < 40))
            send_request($urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_value());
         else
            send_request($urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK, $urandom);
      end
   endtask

   always @(negedge clock) begin
      rsp_bus.ready = ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_rsp.size() == 0) begin
            if (mismatch_count < MAX_REPORTED)
               $display("unexpected transfer: status %0d count %0d",
                        rsp_bus.status, rsp_bus.count);
            mismatch_count++;
         end else begin
            head_rsp = pending_rsp.pop_front();
            if (rsp_bus.status !== head_rsp.status || rsp_bus.count !== head_rsp.count) begin
               if (mismatch_count < MAX_REPORTED)
                  $display("mismatch: expected status %0d count %0d, got status %0d count %0d",
                           head_rsp.status, head_rsp.count, rsp_bus.status, rsp_bus.count);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin
      req_bus.valid    = 1'b0;
      req_bus.req_type = '0;
      req_bus.value    = '0;
      rsp_bus.ready    = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_requests();
      test_fill_to_full();
      test_search_and_pops();
      test_random_traffic(200, 0, 0);
      test_random_traffic(200, 84, 0);
      test_random_traffic(200, 0, 84);
      test_random_traffic(200, 17, 17);
      req_bus.valid = 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_rsp.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
